// File: src/ps2_mouse_cursor_tracker_macros.svh
// assertion macros for the ps2 mouse cursor tracker
// no dependencies; included by modules that carry assertions
`ifndef PS2_MOUSE_CURSOR_TRACKER_MACROS_SVH
`define PS2_MOUSE_CURSOR_TRACKER_MACROS_SVH

`ifndef SYNTHESIS
`define PMCT_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
`define PMCT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next cycle");
`else
`define PMCT_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define PMCT_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// File: src/ps2mct_pkg.sv
// shared types and constants for the ps2 mouse cursor tracker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ps2mct_pkg;

    localparam int SIZE_W      = 13;
    localparam int OUT_COORD_W = 12;
    localparam int BTN_W       = 3;
    localparam int CFG_ADDR_W  = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_WIDTH  = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_HEIGHT = 8'd1;

    localparam int HEAD_Y_OVF  = 7;
    localparam int HEAD_X_OVF  = 6;
    localparam int HEAD_Y_SIGN = 5;
    localparam int HEAD_X_SIGN = 4;

    typedef logic [1:0] byte_idx_t;
    localparam byte_idx_t IDX_HEAD  = 2'd0;
    localparam byte_idx_t IDX_XDATA = 2'd1;
    localparam byte_idx_t IDX_YDATA = 2'd2;

    typedef struct packed {
        logic [7:0] head;
        logic [7:0] xbyte;
        logic [7:0] ybyte;
    } pkt_t;

    typedef struct packed {
        logic [BTN_W-1:0] buttons;
        logic             dropped;
    } res_t;

endpackage

`default_nettype wire

// File: src/ps2mct_decode.sv
// packet decode, delta apply and screen clamp for one complete packet
// depends on ps2mct_pkg
`timescale 1ns / 1ps
`default_nettype none

module ps2mct_decode #(
    parameter int COORD_BITS = 12
) (
    input  wire ps2mct_pkg::pkt_t                 pkt,
    input  wire logic [COORD_BITS-1:0]            pos_x,
    input  wire logic [COORD_BITS-1:0]            pos_y,
    input  wire logic [ps2mct_pkg::BTN_W-1:0]     buttons_in,
    input  wire logic [ps2mct_pkg::SIZE_W-1:0]    screen_width,
    input  wire logic [ps2mct_pkg::SIZE_W-1:0]    screen_height,
    output logic      [COORD_BITS-1:0]            pos_x_new,
    output logic      [COORD_BITS-1:0]            pos_y_new,
    output ps2mct_pkg::res_t                      res
);

    localparam int SW = ((COORD_BITS > 9) ? COORD_BITS : 9) + 2;
    localparam int LW = ((COORD_BITS + 1 > ps2mct_pkg::SIZE_W) ?
                         COORD_BITS + 1 : ps2mct_pkg::SIZE_W) + 1;

    logic          ovf;
    logic [8:0]    dx;
    logic [8:0]    dy;
    logic [SW-1:0] sum_x;
    logic [SW-1:0] sum_y;
    logic [COORD_BITS-1:0] lim_x;
    logic [COORD_BITS-1:0] lim_y;
    logic [COORD_BITS-1:0] clamp_x;
    logic [COORD_BITS-1:0] clamp_y;

    function automatic logic [COORD_BITS-1:0] limit_of(
        input logic [ps2mct_pkg::SIZE_W-1:0] size
    );
        logic [LW-1:0] s;
        logic [LW-1:0] cap;
        logic [LW-1:0] lim;
        s   = {{(LW - ps2mct_pkg::SIZE_W){1'b0}}, size};
        cap = {{(LW - 1){1'b0}}, 1'b1} << COORD_BITS;
        if (s == '0) begin
            s = {{(LW - 1){1'b0}}, 1'b1};
        end
        if (s > cap) begin
            s = cap;
        end
        lim = s - {{(LW - 1){1'b0}}, 1'b1};
        return lim[COORD_BITS-1:0];
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp_to(
        input logic [SW-1:0]         v,
        input logic [COORD_BITS-1:0] hi
    );
        logic [SW-1:0] hi_ext;
        hi_ext = {{(SW - COORD_BITS){1'b0}}, hi};
        if (v[SW-1]) begin
            return '0;
        end else if (v > hi_ext) begin
            return hi;
        end
        return v[COORD_BITS-1:0];
    endfunction

    assign ovf = pkt.head[ps2mct_pkg::HEAD_Y_OVF] | pkt.head[ps2mct_pkg::HEAD_X_OVF];
    assign dx  = {pkt.head[ps2mct_pkg::HEAD_X_SIGN], pkt.xbyte};
    assign dy  = {pkt.head[ps2mct_pkg::HEAD_Y_SIGN], pkt.ybyte};

    // screen y grows downward, so the y delta is subtracted
    assign sum_x = {{(SW - COORD_BITS){1'b0}}, pos_x} + {{(SW - 9){dx[8]}}, dx};
    assign sum_y = {{(SW - COORD_BITS){1'b0}}, pos_y} - {{(SW - 9){dy[8]}}, dy};

    assign lim_x   = limit_of(screen_width);
    assign lim_y   = limit_of(screen_height);
    assign clamp_x = clamp_to(sum_x, lim_x);
    assign clamp_y = clamp_to(sum_y, lim_y);

    always_comb begin
        if (ovf) begin
            pos_x_new   = pos_x;
            pos_y_new   = pos_y;
            res.buttons = buttons_in;
        end else begin
            pos_x_new   = clamp_x;
            pos_y_new   = clamp_y;
            res.buttons = pkt.head[ps2mct_pkg::BTN_W-1:0];
        end
        res.dropped = ovf;
    end

endmodule

`default_nettype wire

// File: src/ps2_mouse_cursor_tracker.sv
// top level: ps2 mouse byte stream in, clamped cursor position out
// depends on ps2mct_pkg, ps2mct_decode and ps2_mouse_cursor_tracker_macros.svh
//
// channel  direction  handshake             payload
// s_       in         s_tvalid / s_tready   s_tdata: rx_byte
// m_       out        m_tvalid / m_tready   m_tdata: cursor_x, cursor_y, buttons
//                                           m_tuser: dropped
// cfg_     in         cfg_valid / cfg_ready cfg_addr, cfg_data (screen size)
//
// one byte per cycle unless a waiting result stalls a third byte; each byte sits in the
// input register, where the third byte of a packet is decoded and clamped, and the
// result register loads when that byte advances out of the input register.
// reset clears the byte counter, position, buttons and sets screen 80 x 25.
// a waiting result stalls only a third byte; header and x bytes keep flowing.
`timescale 1ns / 1ps
`default_nettype none
`include "ps2_mouse_cursor_tracker_macros.svh"

module ps2_mouse_cursor_tracker #(
    parameter int COORD_BITS = 12
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata: [7:0] rx_byte
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,
    // m_tdata: [11:0] cursor_x, [23:12] cursor_y, [26:24] buttons, [31:27] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,
    // m_tuser: [0] dropped
    output logic             m_tuser,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [ps2mct_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [ps2mct_pkg::SIZE_W-1:0]     cfg_data
);

    logic                          in_valid_reg;
    logic [7:0]                    in_byte_reg;
    ps2mct_pkg::byte_idx_t         byte_index_reg;
    logic [7:0]                    pkt0_reg;
    logic [7:0]                    pkt1_reg;
    logic [COORD_BITS-1:0]         pos_x_reg;
    logic [COORD_BITS-1:0]         pos_y_reg;
    logic [ps2mct_pkg::BTN_W-1:0]  btn_reg;
    logic [ps2mct_pkg::SIZE_W-1:0] width_reg;
    logic [ps2mct_pkg::SIZE_W-1:0] height_reg;
    logic                          m_valid_reg;
    logic                          m_valid_next;
    logic [ps2mct_pkg::OUT_COORD_W-1:0] out_x_reg;
    logic [ps2mct_pkg::OUT_COORD_W-1:0] out_y_reg;
    logic [ps2mct_pkg::BTN_W-1:0]  out_btn_reg;
    logic                          out_drop_reg;

    logic                          last_byte;
    logic                          advance;
    ps2mct_pkg::pkt_t              pkt;
    ps2mct_pkg::res_t              res;
    logic [COORD_BITS-1:0]         pos_x_new;
    logic [COORD_BITS-1:0]         pos_y_new;

    assign last_byte = (byte_index_reg == ps2mct_pkg::IDX_YDATA);
    assign advance   = in_valid_reg && (!last_byte || !m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign pkt.head  = pkt0_reg;
    assign pkt.xbyte = pkt1_reg;
    assign pkt.ybyte = in_byte_reg;

    ps2mct_decode #(
        .COORD_BITS(COORD_BITS)
    ) u_decode (
        .pkt          (pkt),
        .pos_x        (pos_x_reg),
        .pos_y        (pos_y_reg),
        .buttons_in   (btn_reg),
        .screen_width (width_reg),
        .screen_height(height_reg),
        .pos_x_new    (pos_x_new),
        .pos_y_new    (pos_y_new),
        .res          (res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance && last_byte) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            byte_index_reg <= ps2mct_pkg::IDX_HEAD;
            pkt0_reg       <= '0;
            pkt1_reg       <= '0;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            btn_reg        <= '0;
            width_reg      <= 13'd80;
            height_reg     <= 13'd25;
            m_valid_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
                in_byte_reg  <= s_tdata;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                unique case (byte_index_reg)
                    ps2mct_pkg::IDX_HEAD: begin
                        pkt0_reg       <= in_byte_reg;
                        byte_index_reg <= ps2mct_pkg::IDX_XDATA;
                    end
                    ps2mct_pkg::IDX_XDATA: begin
                        pkt1_reg       <= in_byte_reg;
                        byte_index_reg <= ps2mct_pkg::IDX_YDATA;
                    end
                    default: begin
                        byte_index_reg <= ps2mct_pkg::IDX_HEAD;
                        pos_x_reg      <= pos_x_new;
                        pos_y_reg      <= pos_y_new;
                        btn_reg        <= res.buttons;
                        out_x_reg      <= ps2mct_pkg::OUT_COORD_W'(pos_x_new);
                        out_y_reg      <= ps2mct_pkg::OUT_COORD_W'(pos_y_new);
                        out_btn_reg    <= res.buttons;
                        out_drop_reg   <= res.dropped;
                    end
                endcase
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_addr)
                    ps2mct_pkg::REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                    ps2mct_pkg::REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, out_btn_reg, out_y_reg, out_x_reg};
    assign m_tuser  = out_drop_reg;

    // a result only follows a third byte
    `PMCT_ASSERT_IMPLY(a_result_after_third, aclk, aresetn,
        $rose(m_valid_reg), $past(advance && last_byte))
    // a dropped packet leaves the position alone
    `PMCT_ASSERT_NEXT(a_drop_holds_pos, aclk, aresetn,
        advance && last_byte && res.dropped,
        $stable(pos_x_reg) && $stable(pos_y_reg))
    // the counter wraps after the third byte
    `PMCT_ASSERT_NEXT(a_index_wrap, aclk, aresetn,
        advance && last_byte, byte_index_reg == ps2mct_pkg::IDX_HEAD)

endmodule

`default_nettype wire
